>>> design/polygon_triangulation_min_cost_unit_macros.svh
// ----------------------------------------------------------------------------
// Polygon triangulation min cost unit: assertion macros
// Clocked property wrappers used by the controller.
// ----------------------------------------------------------------------------
`ifndef POLYGON_TRIANGULATION_MIN_COST_UNIT_MACROS_SVH
`define POLYGON_TRIANGULATION_MIN_COST_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PTMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PTMC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PTMC_ASSERT(lbl, prop, msg)
`define PTMC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> design/ptmc_pkg.sv
// ----------------------------------------------------------------------------
// Polygon triangulation min cost package
// Status codes and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptmc_pkg;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned COST_W       = 32;
  localparam int unsigned SPLIT_W      = 5;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned MIN_VERTICES = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_MANY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic ch_rd;
    logic ch_mul;
    logic ch_sum;
    logic sq_step;
    logic k_rd;
    logic k_first;
    logic wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic stat_ok;
    logic out_free;
  } sts_t;

endpackage

>>> design/polygon_triangulation_min_cost_unit.sv
// ----------------------------------------------------------------------------
// Polygon triangulation min cost unit
// Loads polygon vertices and finds the minimum total chord length
// triangulation with an interval dynamic program.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   tdata: x_coord, y_coord; tlast: last_vertex
// m_axis    out  tdata: total_cost, root_split; tuser: status
//
// A vertex word that is not last only loads. The last word runs the
// program: each span (i,j) is costed by the one-digit-per-cycle square
// root and the one-split-per-cycle scan over the two-read-port span cost
// memory; then the result register loads.
// s_axis_tready is high only while idle. No clearing pass after reset.
// m_axis stalls hold the result; the block waits to load the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_triangulation_min_cost_unit import ptmc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // total_cost[31:0], root_split[36:32], zero
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned IW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  cmd_t               cmd;
  sts_t               sts;
  logic [IW-1:0]      idx_i, idx_j, idx_k;
  logic [CW-1:0]      n;
  logic [COST_W-1:0]  cost;
  logic [SPLIT_W-1:0] split;
  logic [STAT_W-1:0]  stat;

  ptmc_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_last_i (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts),
    .n_i       (n),
    .i_o       (idx_i),
    .j_o       (idx_j),
    .k_o       (idx_k)
  );

  ptmc_dp #(
    .MAX_VERTICES(MAX_VERTICES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .i_i        (idx_i),
    .j_i        (idx_j),
    .k_i        (idx_k),
    .n_o        (n),
    .x_i        (s_axis_tdata[15:0]),
    .y_i        (s_axis_tdata[31:16]),
    .last_i     (s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_cost_o (cost),
    .out_split_o(split),
    .out_stat_o (stat)
  );

  assign m_axis_tdata = {3'b000, split, cost};
  assign m_axis_tuser = stat;

endmodule

>>> design/ptmc_dp.sv
// ----------------------------------------------------------------------------
// Polygon triangulation datapath
// Vertex stores, span cost memory, chord length unit with a digit-serial
// square root, split minimum search and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptmc_dp import ptmc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned FRAC_BITS    = 8,
  localparam int unsigned IW = $clog2(MAX_VERTICES),
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic [IW-1:0]             i_i,
  input  logic [IW-1:0]             j_i,
  input  logic [IW-1:0]             k_i,
  output logic [CW-1:0]             n_o,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  input  logic                      last_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [COST_W-1:0]         out_cost_o,
  output logic [SPLIT_W-1:0]        out_split_o,
  output logic [STAT_W-1:0]         out_stat_o
);

  localparam int unsigned RTW   = 17 + FRAC_BITS;
  localparam int unsigned RW    = RTW + 2;
  localparam int unsigned SW    = 34;
  localparam int unsigned SUMW  = COST_W + 1;
  localparam int unsigned TOTW  = COST_W + 2;
  localparam int unsigned DEPTH = 1 << (2 * IW);

  logic signed [COORD_W-1:0] x_mem [MAX_VERTICES];
  logic signed [COORD_W-1:0] y_mem [MAX_VERTICES];
  logic [COST_W-1:0]         cost_mem [DEPTH];

  logic [CW-1:0]  cnt_q, n_q, cnt_inc;
  logic           ovf_q, ovf_nx, full;
  status_e        stat_q;

  logic signed [COORD_W-1:0] xi_q, xj_q, yi_q, yj_q;
  logic signed [COORD_W:0]   dxs, dys;
  logic [COORD_W-1:0]        adx, ady;
  logic [COST_W-1:0]         sqx_q, sqy_q;
  logic [SW-1:0]             s_q;
  logic [RTW-1:0]            root_q;
  logic [RW-1:0]             rem_q, rem_sh, trial;
  logic [63:0]               root64;
  logic [COST_W-1:0]         chord_w;

  logic [COST_W-1:0] lc_q, rc_q;
  logic              lz_q, rz_q, kv_q, kf_q;
  logic [IW-1:0]     kk_q, bestk_q, res_split_q;
  logic [SUMW-1:0]   q_sum, best_q;
  logic [TOTW-1:0]   total;
  logic [COST_W-1:0] wval, res_cost_q;

  logic              out_valid_q;

  assign full    = (cnt_q == CW'(MAX_VERTICES));
  assign cnt_inc = full ? cnt_q : cnt_q + CW'(1);
  assign ovf_nx  = ovf_q | full;

  assign dxs = {xj_q[COORD_W-1], xj_q} - {xi_q[COORD_W-1], xi_q};
  assign dys = {yj_q[COORD_W-1], yj_q} - {yi_q[COORD_W-1], yi_q};
  assign adx = dxs[COORD_W] ? COORD_W'(-dxs) : dxs[COORD_W-1:0];
  assign ady = dys[COORD_W] ? COORD_W'(-dys) : dys[COORD_W-1:0];

  assign rem_sh  = {rem_q[RW-3:0], s_q[SW-1:SW-2]};
  assign trial   = {root_q, 2'b01};
  assign root64  = 64'(root_q);
  assign chord_w = (|root64[63:32]) ? '1 : root64[31:0];

  assign q_sum = (lz_q ? SUMW'(0) : SUMW'(lc_q)) + (rz_q ? SUMW'(0) : SUMW'(rc_q));
  assign total = TOTW'(best_q) + TOTW'(chord_w);
  assign wval  = (|total[TOTW-1:COST_W]) ? '1 : total[COST_W-1:0];

  assign sts_o.stat_ok  = (stat_q == ST_OK);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign n_o            = n_q;
  assign out_valid_o    = out_valid_q;

  // vertex count and polygon status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      n_q    <= '0;
      stat_q <= ST_OK;
    end else if (cmd_i.load) begin
      if (last_i) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        n_q   <= cnt_inc;
        if (ovf_nx) begin
          stat_q <= ST_MANY;
        end else if (cnt_inc < CW'(MIN_VERTICES)) begin
          stat_q <= ST_FEW;
        end else begin
          stat_q <= ST_OK;
        end
      end else begin
        cnt_q <= cnt_inc;
        ovf_q <= ovf_nx;
      end
    end
  end

  // vertex stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      x_mem[cnt_q[IW-1:0]] <= x_i;
      y_mem[cnt_q[IW-1:0]] <= y_i;
    end
    if (cmd_i.ch_rd) begin
      xi_q <= x_mem[i_i];
      xj_q <= x_mem[j_i];
      yi_q <= y_mem[i_i];
      yj_q <= y_mem[j_i];
    end
  end

  // chord length: squares, sum, then one root digit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.ch_mul) begin
      sqx_q <= COST_W'(32'(adx) * 32'(adx));
      sqy_q <= COST_W'(32'(ady) * 32'(ady));
    end
    if (cmd_i.ch_sum) begin
      s_q    <= SW'(sqx_q) + SW'(sqy_q);
      root_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.sq_step) begin
      s_q <= s_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RTW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RTW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kv_q <= 1'b0;
    end else begin
      kv_q <= cmd_i.k_rd;
    end
  end

  // span cost memory, split search, span write
  always_ff @(posedge clk_i) begin
    if (cmd_i.k_rd) begin
      lc_q <= cost_mem[{i_i, k_i}];
      rc_q <= cost_mem[{k_i, j_i}];
      lz_q <= (k_i == i_i + IW'(1));
      rz_q <= (k_i + IW'(1) == j_i);
      kf_q <= cmd_i.k_first;
      kk_q <= k_i;
    end
    if (kv_q && (kf_q || q_sum < best_q)) begin
      best_q  <= q_sum;
      bestk_q <= kk_q;
    end
    if (cmd_i.wr) begin
      cost_mem[{i_i, j_i}] <= wval;
      res_cost_q           <= wval;
      res_split_q          <= bestk_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_stat_o <= stat_q;
      if (stat_q == ST_OK) begin
        out_cost_o  <= res_cost_q;
        out_split_o <= SPLIT_W'(res_split_q);
      end else begin
        out_cost_o  <= '0;
        out_split_o <= '0;
      end
    end
  end

endmodule

>>> design/ptmc_ctrl.sv
// ----------------------------------------------------------------------------
// Polygon triangulation controller
// Sequences vertex loading and the interval program: span length, span
// start, chord root steps and the split scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polygon_triangulation_min_cost_unit_macros.svh"

module ptmc_ctrl import ptmc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned FRAC_BITS    = 8,
  localparam int unsigned IW = $clog2(MAX_VERTICES),
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output cmd_t          cmd_o,
  input  sts_t          sts_i,
  input  logic [CW-1:0] n_i,
  output logic [IW-1:0] i_o,
  output logic [IW-1:0] j_o,
  output logic [IW-1:0] k_o
);

  localparam int unsigned SQ_STEPS = 17 + FRAC_BITS;
  localparam int unsigned SQW      = $clog2(SQ_STEPS);

  typedef enum logic [3:0] {
    IDLE, CHECK, CH_RD, CH_MUL, CH_SUM, SQRT, K_RUN, K_DRAIN, WR, FIN
  } state_e;

  state_e         state_q;
  logic [IW-1:0]  len_q, i_q, k_q, j;
  logic [SQW-1:0] sq_q;
  logic           load;

  assign j          = i_q + len_q;
  assign in_ready_o = (state_q == IDLE);
  assign load       = in_valid_i && in_ready_o;
  assign i_o        = i_q;
  assign j_o        = j;
  assign k_o        = k_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = load;
    cmd_o.ch_rd   = (state_q == CH_RD);
    cmd_o.ch_mul  = (state_q == CH_MUL);
    cmd_o.ch_sum  = (state_q == CH_SUM);
    cmd_o.sq_step = (state_q == SQRT);
    cmd_o.k_rd    = (state_q == K_RUN);
    cmd_o.k_first = (state_q == K_RUN) && (k_q == i_q + IW'(1));
    cmd_o.wr      = (state_q == WR);
    cmd_o.fin     = (state_q == FIN) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      len_q   <= '0;
      i_q     <= '0;
      k_q     <= '0;
      sq_q    <= '0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (load && in_last_i) begin
            state_q <= CHECK;
          end
        end
        CHECK: begin
          if (sts_i.stat_ok) begin
            len_q   <= IW'(2);
            i_q     <= '0;
            state_q <= CH_RD;
          end else begin
            state_q <= FIN;
          end
        end
        CH_RD:  state_q <= CH_MUL;
        CH_MUL: state_q <= CH_SUM;
        CH_SUM: begin
          sq_q    <= SQW'(SQ_STEPS - 1);
          state_q <= SQRT;
        end
        SQRT: begin
          if (sq_q == '0) begin
            k_q     <= i_q + IW'(1);
            state_q <= K_RUN;
          end else begin
            sq_q <= sq_q - SQW'(1);
          end
        end
        K_RUN: begin
          if (k_q + IW'(1) == j) begin
            state_q <= K_DRAIN;
          end else begin
            k_q <= k_q + IW'(1);
          end
        end
        K_DRAIN: state_q <= WR;
        WR: begin
          if (CW'(i_q) + CW'(len_q) + CW'(1) < n_i) begin
            i_q     <= i_q + IW'(1);
            state_q <= CH_RD;
          end else if (CW'(len_q) + CW'(1) < n_i) begin
            len_q   <= len_q + IW'(1);
            i_q     <= '0;
            state_q <= CH_RD;
          end else begin
            state_q <= FIN;
          end
        end
        FIN: begin
          if (sts_i.out_free) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  `PTMC_ASSERT(a_k_in_span, (state_q == K_RUN) |-> (k_q > i_q && k_q < j), "split outside span")
  `PTMC_ASSERT(a_span_end, (state_q == CH_RD) |-> (CW'(j) < n_i), "span end beyond vertex count")
  `PTMC_ASSERT(a_wr_next, (state_q == WR) |=> (state_q == CH_RD || state_q == FIN), "bad step after span write")

endmodule

>>> bench/ptmc_checker.sv
// ----------------------------------------------------------------------------
// Polygon triangulation min cost checker
// Watches both streams, rebuilds each polygon from the accepted vertex words,
// runs the interval program on each polygon of valid size and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptmc_checker import ptmc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned FRAC_BITS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [SPLIT_W-1:0] split;
    status_e            status;
  } tri_res_t;

  logic signed [COORD_W-1:0] vx [MAX_VERTICES];
  logic signed [COORD_W-1:0] vy [MAX_VERTICES];
  logic [COST_W-1:0]         span_cost [MAX_VERTICES][MAX_VERTICES];
  logic [SPLIT_W-1:0]        span_split [MAX_VERTICES][MAX_VERTICES];
  int unsigned               nverts;
  bit                        overflow;
  tri_res_t                  expected_q [$];

  function automatic logic [31:0] chord_len(int unsigned a, int unsigned b);
    longint unsigned dx, dy, s, root, rem, trial, digit;
    dx = (vx[b] > vx[a]) ? longint'(vx[b]) - vx[a] : longint'(vx[a]) - vx[b];
    dy = (vy[b] > vy[a]) ? longint'(vy[b]) - vy[a] : longint'(vy[a]) - vy[b];
    s = dx * dx + dy * dy;
    root = 0;
    rem = 0;
    for (int t = 16 + FRAC_BITS; t >= 0; t--) begin
      digit = (t >= FRAC_BITS) ? ((s >> (2 * (t - FRAC_BITS))) & 3) : 0;
      rem = (rem << 2) | digit;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
  endfunction

  function automatic tri_res_t triangulate(int unsigned n);
    tri_res_t r;
    longint unsigned best, q, total;
    int unsigned bk, j;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      span_cost[i][i+1] = '0;
      span_split[i][i+1] = '0;
    end
    for (int unsigned len = 2; len < n; len++) begin
      for (int unsigned i = 0; i + len < n; i++) begin
        j = i + len;
        best = 0;
        bk = i + 1;
        for (int unsigned k = i + 1; k < j; k++) begin
          q = longint'(span_cost[i][k]) + longint'(span_cost[k][j]);
          if (k == i + 1 || q < best) begin
            best = q;
            bk = k;
          end
        end
        total = best + chord_len(i, j);
        span_cost[i][j] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        span_split[i][j] = bk[SPLIT_W-1:0];
      end
    end
    r.cost = span_cost[0][n-1];
    r.split = span_split[0][n-1];
    r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tri_res_t r;
    tri_res_t got;
    if (!rst_ni) begin
      nverts = 0;
      overflow = 1'b0;
      errors_o <= 0;
      pending_o <= 0;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cost = m_axis_tdata[31:0];
        got.split = m_axis_tdata[36:32];
        got.status = status_e'(m_axis_tuser);
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: unexpected result word %h", got);
          errors_o <= errors_o + 1;
        end else begin
          r = expected_q.pop_front();
          if (got !== r || m_axis_tdata[39:37] !== 3'b0) begin
            if (errors_o < 10)
              $display("ERROR: cost %0d/%0d split %0d/%0d status %0d/%0d (exp/got)",
                       r.cost, got.cost, r.split, got.split, r.status, got.status);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (nverts < MAX_VERTICES) begin
          vx[nverts] = s_axis_tdata[15:0];
          vy[nverts] = s_axis_tdata[31:16];
          nverts++;
        end else begin
          overflow = 1'b1;
        end
        if (s_axis_tlast) begin
          if (overflow) r = '{cost: '0, split: '0, status: ST_MANY};
          else if (nverts < MIN_VERTICES) r = '{cost: '0, split: '0, status: ST_FEW};
          else r = triangulate(nverts);
          expected_q.insert(expected_q.size(), r);
          nverts = 0;
          overflow = 1'b0;
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> bench/tb_polygon_triangulation_min_cost_unit.sv
// ----------------------------------------------------------------------------
// Polygon triangulation min cost unit testbench
// Sends directed and random polygons (short, full, oversized, extreme
// coordinates) under several idle patterns and a long output stall; the
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polygon_triangulation_min_cost_unit;
  import ptmc_pkg::*;

  localparam int unsigned MAXV = 32;
  localparam int unsigned LIMIT = 12_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          errors;
  int          pending;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_armed = 1'b1;
  int          hold_cycles = 0;
  int unsigned cycles = 0;

  polygon_triangulation_min_cost_unit #(.MAX_VERTICES(MAXV), .FRAC_BITS(8)) i_dut (.*);

  ptmc_checker #(.MAX_VERTICES(MAXV), .FRAC_BITS(8)) i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req && hold_armed) begin
      m_axis_tready <= 1'b0;
      hold_armed <= 1'b0;
      hold_cycles <= 30000;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_polygon(int n, int mode);
    logic [15:0] x, y;
    int amp;
    amp = 1 << $urandom_range(15, 2);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin
          x = 16'($urandom_range(amp - 1) - amp / 2);
          y = 16'($urandom_range(amp - 1) - amp / 2);
        end
        2: begin
          x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
          y = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        end
        default: begin x = 16'd5; y = 16'd5; end
      endcase
      send_vertex(x, y, i == n - 1);
    end
  endtask

  task automatic random_polygon();
    int r, n;
    r = $urandom_range(99);
    if (r < 8) n = $urandom_range(2, 1);
    else if (r < 14) n = $urandom_range(40, 33);
    else if (r < 20) n = $urandom_range(32, 24);
    else n = $urandom_range(12, 3);
    send_polygon(n, $urandom_range(9) < 6 ? 1 : $urandom_range(3));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: short, three, full, oversized, extremes, coincident
    send_polygon(1, 1);
    send_polygon(2, 0);
    send_vertex(16'h8000, 16'h8000, 1'b0);
    send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
    send_vertex(16'h8000, 16'h7FFF, 1'b1);
    send_polygon(4, 3);
    send_polygon(5, 2);
    send_polygon(32, 2);
    send_polygon(33, 1);
    send_polygon(3, 0);
    drain();
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 72 : 17) : 0;
      snk_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 72 : 17) : 0;
      if (ph == 2) hold_req = 1'b1;
      for (int p = 0; p < 45; p++) random_polygon();
      drain();
    end
    repeat (5000) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
